FILE: design/mdd_pkg.sv
// Shared constants for the maximum drawdown tracker.
// No dependencies; imported by mdd_div and max_drawdown_tracker.
package mdd_pkg;

  localparam int PRICE_BITS    = 32;
  localparam int INDEX_BITS    = 20;
  localparam int FRACTION_BITS = 16;

  // The drawdown carries one integer bit so that a full loss reads as 1.0.
  localparam int DD_BITS = FRACTION_BITS + 1;

  // Step counter of the divider: one step per quotient bit.
  localparam int STEP_BITS = $clog2(DD_BITS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DD_BITS - 1);

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } mdd_state_t;

endpackage

FILE: design/max_drawdown_tracker.sv
// Top level of the maximum drawdown tracker.
// Depends on mdd_pkg and instantiates the shared divider mdd_div.
//
// The block takes one price word per item and follows a price series until a
// word marked with series_end arrives. It keeps the running peak and its
// index, and the largest drawdown (peak - price) / peak seen so far as an
// unsigned fraction with 16 fraction bits, truncated toward zero; a drawdown
// of 65536 means a full loss and a zero peak gives a drawdown of 0. Only a
// strictly larger drawdown replaces the stored one, so the earliest of equal
// drawdowns is kept together with its peak and trough indices. The marked
// word produces one result word (drawdown, peak_position, trough_position)
// and the tracker then starts afresh; other words produce nothing. Indices
// count from 0 and saturate at 2^20 - 1. Each word goes through these steps:
// accepting it and updating the peak, the restoring divider that forms one
// quotient bit per cycle, registering the divider's done pulse, and folding
// the quotient into the best drawdown. in_stall is high from the accepting
// edge until that fold. The result sits in an output register, so a stalled
// result holds back the tracker only when the next series ends before the
// previous result has been taken.
module max_drawdown_tracker
  import mdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PRICE_BITS-1:0] price,
  input  logic                  series_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DD_BITS-1:0]    drawdown,
  output logic [INDEX_BITS-1:0] peak_position,
  output logic [INDEX_BITS-1:0] trough_position
);

  mdd_state_t state;

  logic [PRICE_BITS-1:0] running_peak;
  logic [INDEX_BITS-1:0] running_peak_position;
  logic [DD_BITS-1:0]    best_drawdown;
  logic [INDEX_BITS-1:0] best_peak_position;
  logic [INDEX_BITS-1:0] best_trough_position;
  logic [INDEX_BITS-1:0] item_position;

  // Details of the word in flight.
  logic                  last_word;
  logic [INDEX_BITS-1:0] word_position;

  logic                  in_accept;
  logic                  new_peak;
  logic [PRICE_BITS-1:0] peak_next;
  logic [PRICE_BITS-1:0] diff;
  logic                  div_done;
  logic                  div_done_seen;
  logic [DD_BITS-1:0]    quotient;
  logic [DD_BITS-1:0]    word_drawdown;
  logic                  better;
  logic                  out_free;
  logic                  commit;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // A new high makes this word the peak; its own drawdown is then zero.
  assign new_peak  = (price > running_peak);
  assign peak_next = new_peak ? price : running_peak;
  assign diff      = peak_next - price;

  mdd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .dividend (diff),
    .divisor  (peak_next),
    .done     (div_done),
    .quotient (quotient)
  );

  // With a zero peak the divider result means nothing and the drawdown is 0.
  assign word_drawdown = (running_peak == '0) ? '0 : quotient;
  assign better        = (word_drawdown > best_drawdown);

  // The output register is free when empty or being emptied at this edge.
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == ST_DIV) && div_done_seen && (!last_word || out_free);

  // The divider pulses done for one cycle; hold it while the result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_done_seen <= 1'b0;
    end else if (in_accept || commit) begin
      div_done_seen <= 1'b0;
    end else if (div_done) begin
      div_done_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak          <= '0;
      running_peak_position <= '0;
      best_drawdown         <= '0;
      best_peak_position    <= '0;
      best_trough_position  <= '0;
      item_position         <= '0;
    end else if (in_accept) begin
      running_peak <= peak_next;
      if (new_peak) begin
        running_peak_position <= item_position;
      end
      if (item_position != INDEX_MAX) begin
        item_position <= item_position + 1'b1;
      end
    end else if (commit) begin
      if (last_word) begin
        // The series is over: start the next one from a clean slate.
        running_peak          <= '0;
        running_peak_position <= '0;
        best_drawdown         <= '0;
        best_peak_position    <= '0;
        best_trough_position  <= '0;
        item_position         <= '0;
      end else if (better) begin
        best_drawdown        <= word_drawdown;
        best_peak_position   <= running_peak_position;
        best_trough_position <= word_position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      last_word     <= series_end;
      word_position <= item_position;
    end
  end

  // Output register for the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && last_word) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && last_word) begin
      if (better) begin
        drawdown        <= word_drawdown;
        peak_position   <= running_peak_position;
        trough_position <= word_position;
      end else begin
        drawdown        <= best_drawdown;
        peak_position   <= best_peak_position;
        trough_position <= best_trough_position;
      end
    end
  end

endmodule

FILE: design/mdd_div.sv
// Radix-2 restoring divider that yields floor(dividend * 2^FRACTION_BITS / divisor).
// Depends on mdd_pkg. One quotient bit per cycle, integer bit first.
module mdd_div
  import mdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PRICE_BITS-1:0] dividend,
  input  logic [PRICE_BITS-1:0] divisor,
  output logic                  done,
  output logic [DD_BITS-1:0]    quotient
);

  logic                  busy;
  logic [STEP_BITS-1:0]  step;
  logic [PRICE_BITS-1:0] rem;
  logic [PRICE_BITS-1:0] div_reg;
  logic [PRICE_BITS:0]   rem_shifted;
  logic [PRICE_BITS:0]   rem_diff;
  logic                  take;

  // The integer bit compares the dividend itself; later bits shift first.
  always_comb begin
    if (step == '0) begin
      rem_shifted = {1'b0, rem};
    end else begin
      rem_shifted = {rem, 1'b0};
    end
    rem_diff = rem_shifted - {1'b0, div_reg};
    take     = (rem_shifted >= {1'b0, div_reg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      div_reg  <= divisor;
      quotient <= '0;
    end else if (busy) begin
      // The remainder stays below the divisor, so it fits PRICE_BITS.
      if (take) begin
        rem <= rem_diff[PRICE_BITS-1:0];
      end else begin
        rem <= rem_shifted[PRICE_BITS-1:0];
      end
      quotient <= {quotient[DD_BITS-2:0], take};
    end
  end

endmodule

FILE: sim/tb_max_drawdown_tracker.sv
// Self-checking testbench for max_drawdown_tracker: drives price series and
// checks every drawdown result against a predictor kept in this file.
// Depends on mdd_pkg and the max_drawdown_tracker RTL.
module tb_max_drawdown_tracker;
  import mdd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One result word as the tracker emits it at the end of a series.
  typedef struct packed {
    logic [DD_BITS-1:0]    drawdown;
    logic [INDEX_BITS-1:0] peak_position;
    logic [INDEX_BITS-1:0] trough_position;
  } drawdown_report_t;

  localparam logic [PRICE_BITS-1:0] PRICE_MAX = {PRICE_BITS{1'b1}};

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [PRICE_BITS-1:0] price;
  logic                  series_end;
  logic                  out_valid;
  logic                  out_stall;
  logic [DD_BITS-1:0]    drawdown;
  logic [INDEX_BITS-1:0] peak_position;
  logic [INDEX_BITS-1:0] trough_position;

  // Predictor state for the series in progress. Reset is applied exactly once,
  // so the declaration values stand for the state after reset.
  logic [PRICE_BITS-1:0] peak_price     = '0;
  logic [INDEX_BITS-1:0] peak_at        = '0;
  logic [DD_BITS-1:0]    best_dd        = '0;
  logic [INDEX_BITS-1:0] best_peak_at   = '0;
  logic [INDEX_BITS-1:0] best_trough_at = '0;
  logic [INDEX_BITS-1:0] next_index     = '0;

  // Reports that the tracker still owes us, oldest first.
  drawdown_report_t results_due[$];

  int mismatches  = 0;
  int hold_cycles = 0;  // a long receiver hold-off requested by a test
  bit in_idle     = 1'b1;  // sender inserts random gaps between words
  bit out_idle    = 1'b1;  // receiver stalls at random before each word

  max_drawdown_tracker dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .price           (price),
    .series_end      (series_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .drawdown        (drawdown),
    .peak_position   (peak_position),
    .trough_position (trough_position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The drawdown fraction is floor(fall * 2^FRACTION_BITS / top). Since the
  // fall never exceeds the peak, the quotient fits in DD_BITS, and a full
  // loss lands exactly on 1 << FRACTION_BITS.
  function automatic logic [DD_BITS-1:0] drawdown_fraction(
    input logic [PRICE_BITS-1:0] fall,
    input logic [PRICE_BITS-1:0] top
  );
    logic [PRICE_BITS+FRACTION_BITS-1:0] scaled;
    scaled = {fall, {FRACTION_BITS{1'b0}}};
    return DD_BITS'(scaled / top);
  endfunction

  // Folds one accepted price word into the predicted state. A word marked as
  // the series end queues the report and starts a fresh series.
  function automatic void track_price(input logic [PRICE_BITS-1:0] p,
                                      input logic last);
    logic [DD_BITS-1:0] dd;
    drawdown_report_t   report;
    dd = '0;
    // A new high moves the peak; the drawdown at this index is then zero.
    if (p > peak_price) begin
      peak_price = p;
      peak_at    = next_index;
    end
    // While the peak is still zero there is nothing to lose.
    if (peak_price != '0) begin
      dd = drawdown_fraction(peak_price - p, peak_price);
    end
    // Only a strictly larger drawdown wins, so the earliest tie is kept.
    if (dd > best_dd) begin
      best_dd        = dd;
      best_peak_at   = peak_at;
      best_trough_at = next_index;
    end
    // The index sticks at its maximum on very long series.
    if (next_index != INDEX_MAX) begin
      next_index = next_index + 1'b1;
    end
    if (last) begin
      report.drawdown        = best_dd;
      report.peak_position   = best_peak_at;
      report.trough_position = best_trough_at;
      results_due = {results_due, report};
      peak_price     = '0;
      peak_at        = '0;
      best_dd        = '0;
      best_peak_at   = '0;
      best_trough_at = '0;
      next_index     = '0;
    end
  endfunction

  // Offers one price word and returns at the edge where it is taken. The
  // valid stays high on return, so a back-to-back word never drops it; the
  // next call lowers it only when it actually inserts a gap.
  task automatic send_word(input logic [PRICE_BITS-1:0] p, input logic last);
    int gap;
    gap = in_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    price      <= p;
    series_end <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_price(p, last);
  endtask

  // Sender pause: valid drops so the word already taken is not offered again,
  // and nothing new goes in until every owed report has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // Hand-picked series for the corners of the arithmetic and the bookkeeping.
  task automatic test_directed_cases();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    // A single-word series reports zero drawdown at index 0, whatever its price.
    send_word('0, 1'b1);
    send_word(PRICE_MAX, 1'b1);
    // Leading zero prices keep the peak at zero until a real price shows up.
    send_word('0, 1'b0);
    send_word('0, 1'b0);
    send_word(32'd100, 1'b0);
    send_word(32'd50, 1'b1);
    // Full loss from the largest price reads as exactly 1.0.
    send_word(PRICE_MAX, 1'b0);
    send_word('0, 1'b1);
    // An equal later drawdown must not displace the first one.
    send_word(32'd100, 1'b0);
    send_word(32'd50, 1'b0);
    send_word(32'd100, 1'b0);
    send_word(32'd50, 1'b1);
    // One third truncates toward zero.
    send_word(32'd3, 1'b0);
    send_word(32'd2, 1'b1);
    // A deeper drop after a new peak replaces both indices.
    send_word(32'd10, 1'b0);
    send_word(32'd9, 1'b0);
    send_word(32'd20, 1'b0);
    send_word(32'd5, 1'b1);
    // A rising series never draws down.
    send_word(32'd1, 1'b0);
    send_word(32'd2, 1'b0);
    send_word(32'd3, 1'b1);
    // A one-tick drop from the top is below one LSB of the fraction.
    send_word(PRICE_MAX, 1'b0);
    send_word(PRICE_MAX - 1'b1, 1'b1);
    wait_for_results();
  endtask

  // Random series of varied length and price shape. Most series are short so
  // that many reports come back; a few run longer to build deeper histories.
  task automatic test_random_series(input int item_goal);
    int     sent;
    int     len;
    int     shape;
    longint level;
    longint span;
    logic [PRICE_BITS-1:0] p;
    sent = 0;
    while (sent < item_goal) begin
      // Switch idling on and off in stretches so both busy and calm phases occur.
      if ($urandom_range(0, 7) == 0) begin
        in_idle  = ($urandom_range(0, 2) != 0);
        out_idle = ($urandom_range(0, 2) != 0);
      end
      // Now and then let everything drain before starting the next series.
      if ($urandom_range(0, 14) == 0) begin
        wait_for_results();
      end
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                          : $urandom_range(1, 12);
      shape = $urandom_range(0, 3);
      level = longint'($urandom);
      for (int k = 0; k < len; k++) begin
        case (shape)
          0: p = $urandom;
          1: begin
            // Random walk around a random level, clamped to the price range.
            span  = (level >> $urandom_range(3, 12)) + 4;
            level = level + longint'($urandom_range(0, 32'(2 * span))) - span;
            if (level < 0) level = 0;
            if (level > longint'(PRICE_MAX)) level = longint'(PRICE_MAX);
            p = PRICE_BITS'(level);
          end
          // Tiny prices give zero peaks and frequent equal drawdowns.
          2: p = $urandom_range(0, 7);
          default: begin
            case ($urandom_range(0, 3))
              0:       p = '0;
              1:       p = PRICE_MAX;
              default: p = $urandom;
            endcase
          end
        endcase
        send_word(p, k == len - 1);
        sent++;
      end
    end
    in_idle  = 1'b1;
    out_idle = 1'b1;
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender pushes a run
  // of short series with no gaps. The first report parks in the output
  // register and the next series end has to wait, so the input stalls too.
  task automatic test_output_backlog();
    wait_for_results();
    in_idle     = 1'b0;
    hold_cycles = 400;
    for (int s = 0; s < 6; s++) begin
      send_word($urandom, 1'b1);
    end
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b1);
    in_idle = 1'b1;
    wait_for_results();
  endtask

  // Receiver stall: a requested hold-off is counted down here; otherwise a
  // fresh random stall is drawn each time a result word is taken.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        stall_left  = hold_cycles;
        hold_cycles = 0;
      end else if (out_valid && !out_stall) begin
        stall_left = out_idle ? $urandom_range(0, 10) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Result checker: every word taken from the block is matched, field by
  // field, against the oldest report still owed.
  initial begin : result_check
    drawdown_report_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (results_due.size() == 0) begin
          $display("%0t unexpected result: expected none, actual dd %0d peak %0d trough %0d",
                   $time, drawdown, peak_position, trough_position);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (drawdown !== want.drawdown) begin
            $display("%0t drawdown mismatch: expected %0d, actual %0d",
                     $time, want.drawdown, drawdown);
            mismatches++;
          end
          if (peak_position !== want.peak_position) begin
            $display("%0t peak_position mismatch: expected %0d, actual %0d",
                     $time, want.peak_position, peak_position);
            mismatches++;
          end
          if (trough_position !== want.trough_position) begin
            $display("%0t trough_position mismatch: expected %0d, actual %0d",
                     $time, want.trough_position, trough_position);
            mismatches++;
          end
        end
      end
    end
  end

  // Main sequence: reset once, run the tests in turn, then let the pipeline
  // settle so that any stray extra word is still caught before the verdict.
  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    price      <= '0;
    series_end <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_backlog();
    test_random_series(720);

    wait_for_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_max_drawdown_tracker: clean");
    end else begin
      $display("tb_max_drawdown_tracker: errors");
    end
    $finish;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    #2ms;
    $display("tb_max_drawdown_tracker: errors");
    $finish;
  end

endmodule

FILE: max_drawdown_tracker.f
design/mdd_pkg.sv
design/mdd_div.sv
design/max_drawdown_tracker.sv
sim/tb_max_drawdown_tracker.sv
